FILE: src/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

  // fraction bits of the log2 result
  localparam int unsigned LOG_FRAC = 28;

  // ln(2) in Q0.28
  localparam logic [27:0] LN2_Q28 = 28'hB17217F;

  // result status codes
  typedef enum logic [2:0] {
    ST_FINITE  = 3'd0,
    ST_PINF    = 3'd1,
    ST_MINF    = 3'd2,
    ST_SAT     = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  // degenerate input classes, resolved at the output stage
  typedef enum logic [2:0] {
    SP_NONE    = 3'd0,
    SP_INVALID = 3'd1,
    SP_PINF    = 3'd2,
    SP_MINF    = 3'd3,
    SP_ZERO    = 3'd4
  } special_t;

endpackage

`default_nettype wire

FILE: src/bsd_log2.sv
`default_nettype none

// pipelined log2 of a 32-bit integer, one fraction bit per stage
// result is e*2^28 + fraction, from an input register and the squaring stages
module bsd_log2 import bsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] x,
  output logic [32:0]      lg
);

  logic [4:0]          e_c;
  logic [31:0]         m_c;
  logic [31:0]         m_r    [LOG_FRAC+1];
  logic [4:0]          e_r    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] frac_r [LOG_FRAC+1];

  // leading one position and normalized mantissa
  always_comb begin
    e_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) e_c = 5'(i);
    end
    m_c = x << (5'd31 - e_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m_c;
      e_r[0]    <= e_c;
      frac_r[0] <= '0;
    end
  end

  // square the mantissa, renormalize when it reaches two
  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_r[g]) * 64'(m_r[g]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[g+1]    <= t[32] ? t[32:1] : t[31:0];
        e_r[g+1]    <= e_r[g];
        frac_r[g+1] <= {frac_r[g][LOG_FRAC-2:0], t[32]};
      end
    end
  end

  assign lg = {e_r[LOG_FRAC], frac_r[LOG_FRAC]};

endmodule

`default_nettype wire

FILE: src/bsd_isqrt.sv
`default_nettype none

// pipelined integer square root of a 60-bit value, one root bit per stage
module bsd_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [59:0] v,
  output logic [29:0]      s
);

  localparam int unsigned NST = 30;

  logic [59:0] rem_w [NST+1];
  logic [59:0] res_w [NST+1];
  logic [59:0] rem_r [NST];
  logic [59:0] res_r [NST];

  assign rem_w[0] = v;
  assign res_w[0] = '0;

  for (genvar g = 0; g < NST; g++) begin : g_st
    localparam logic [59:0] BIT = 60'(1) << (2 * (NST - 1 - g));
    logic [60:0] sum;
    logic        ge;
    assign sum = {1'b0, res_w[g]} + {1'b0, BIT};
    assign ge  = {1'b0, rem_w[g]} >= sum;

    // try the next root bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_w[g] - sum[59:0] : rem_w[g];
        res_r[g] <= ge ? (res_w[g] >> 1) + BIT : (res_w[g] >> 1);
      end
    end

    assign rem_w[g+1] = rem_r[g];
    assign res_w[g+1] = res_r[g];
  end

  assign s = res_w[NST][29:0];

endmodule

`default_nettype wire

FILE: src/bsd_div.sv
`default_nettype none

// pipelined restoring divider, 33 quotient bits with overflow flag
module bsd_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [59:0] num,
  input  wire logic [29:0] den,
  output logic [32:0]      quo,
  output logic             ovf,
  output logic [29:0]      den_out
);

  localparam int unsigned QB = 33;

  logic [59:0] rem_w [QB+1];
  logic [32:0] q_w   [QB+1];
  logic [29:0] d_w   [QB+1];
  logic        o_w   [QB+1];
  logic [59:0] rem0_r;
  logic [29:0] d0_r;
  logic        o0_r;
  logic [59:0] rem_r [QB];
  logic [32:0] q_r   [QB];
  logic [29:0] d_r   [QB];
  logic        o_r   [QB];

  // quotient overflow check against den * 2^33
  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= num;
      d0_r   <= den;
      o0_r   <= {3'b0, num} >= {den, 33'b0};
    end
  end

  assign rem_w[0] = rem0_r;
  assign q_w[0]   = '0;
  assign d_w[0]   = d0_r;
  assign o_w[0]   = o0_r;

  for (genvar g = 0; g < QB; g++) begin : g_st
    logic [62:0] dv;
    logic        ge;
    assign dv = 63'(d_w[g]) << (QB - 1 - g);
    assign ge = {3'b0, rem_w[g]} >= dv;

    // one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_w[g] - dv[59:0] : rem_w[g];
        q_r[g]   <= {q_w[g][31:0], ge};
        d_r[g]   <= d_w[g];
        o_r[g]   <= o_w[g];
      end
    end

    assign rem_w[g+1] = rem_r[g];
    assign q_w[g+1]   = q_r[g];
    assign d_w[g+1]   = d_r[g];
    assign o_w[g+1]   = o_r[g];
  end

  assign quo     = q_w[QB];
  assign ovf     = o_w[QB];
  assign den_out = d_w[QB];

endmodule

`default_nettype wire

FILE: src/black_scholes_d1_d2_core.sv
// Black-Scholes d1/d2 evaluator, fixed point.
// input channel in_*: one item per option, forward, strike (Q16.16),
// volatility (Q2.16) and maturity (Q8.16); output channel out_*: d1 and
// d2 in signed Q8.24 plus a status code (finite, +inf, -inf, saturated,
// invalid). Degenerate inputs are classified and override the result.
// From input acceptance to out_*, an item passes the input stage, the log2
// stages (one squaring multiplier per fraction bit), the log difference
// and ln2 scaling, a 34-stage restoring divider for d1 and the output
// register; the square root of vol^2*mat runs alongside log2. Throughput
// is one item per cycle unless the receiver stalls. Valid bits travel with
// the data. When the receiver stalls, the whole pipeline holds while its
// last stage carries an item; bubbles keep advancing, so the pipeline still
// takes items until a result stands behind the held output register.
// Reset (rst_n low, synchronous) empties the pipeline and the output.
`default_nettype none

module black_scholes_d1_d2_core import bsd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // forward_price[31:0], strike_price[63:32], volatility[81:64],
  // maturity_years[105:82], zero pad
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // d_one[31:0], d_two[63:32], result_status[66:64], zero pad
  output logic [71:0]       out_tdata
);

  localparam int unsigned DEPTH = 67;

  logic              en;
  logic              out_free;
  logic              in_acc;
  logic [DEPTH-1:0]  vld_r;
  logic              out_valid_r;
  logic [71:0]       out_data_r;

  logic [31:0] f_c, k_c;
  logic [17:0] vol_c;
  logic [23:0] mat_c;
  special_t    spec_nxt;

  logic [31:0] f_r, k_r;
  logic [23:0] mat_r;
  logic [35:0] vv_r;
  logic [59:0] v_r;
  logic [32:0] lf, lk;
  logic [29:0] s_w;
  logic [32:0] ldiff_r;
  logic        lneg_r;
  logic [52:0] mag_r;
  logic        mneg_r;
  logic [60:0] magp;
  logic [59:0] nmag_r;
  logic        nneg_r;
  logic [29:0] s_r;
  logic [32:0] quo;
  logic        ovf;
  logic [29:0] sd;

  special_t    spec_dl [DEPTH];
  logic [58:0] vh_dl   [30];
  logic        nneg_dl [34];

  assign f_c   = in_tdata[31:0];
  assign k_c   = in_tdata[63:32];
  assign vol_c = in_tdata[81:64];
  assign mat_c = in_tdata[105:82];

  // handshake and pipeline enable
  assign out_free  = !out_valid_r || out_tready;
  assign en        = out_free || !vld_r[DEPTH-1];
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_acc};
    end
  end

  // degenerate input classes
  always_comb begin
    if (f_c == '0 && k_c == '0) spec_nxt = SP_INVALID;
    else if (k_c == '0) spec_nxt = SP_PINF;
    else if (f_c == '0) spec_nxt = SP_MINF;
    else if (vol_c == '0 || mat_c == '0) begin
      if (f_c > k_c) spec_nxt = SP_PINF;
      else if (f_c == k_c) spec_nxt = SP_ZERO;
      else spec_nxt = SP_MINF;
    end else spec_nxt = SP_NONE;
  end

  // input stage and vol^2
  always_ff @(posedge clk) begin
    if (en) begin
      f_r   <= f_c;
      k_r   <= k_c;
      mat_r <= mat_c;
      vv_r  <= 36'(vol_c) * 36'(vol_c);
    end
  end

  // side data delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      spec_dl[0] <= spec_nxt;
      for (int i = 1; i < DEPTH; i++) spec_dl[i] <= spec_dl[i-1];
      vh_dl[0] <= v_r[59:1];
      for (int i = 1; i < 30; i++) vh_dl[i] <= vh_dl[i-1];
      nneg_dl[0] <= nneg_r;
      for (int i = 1; i < 34; i++) nneg_dl[i] <= nneg_dl[i-1];
    end
  end

  // variance vol^2 * mat in Q12.48
  always_ff @(posedge clk) begin
    if (en) v_r <= 60'(vv_r) * 60'(mat_r);
  end

  bsd_log2 u_log_f (.clk(clk), .en(en), .x(f_r), .lg(lf));
  bsd_log2 u_log_k (.clk(clk), .en(en), .x(k_r), .lg(lk));
  bsd_isqrt u_sqrt (.clk(clk), .en(en), .v(v_r), .s(s_w));

  // log difference magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      lneg_r  <= lf < lk;
      ldiff_r <= (lf < lk) ? lk - lf : lf - lk;
    end
  end

  // scale by ln2
  assign magp = 61'(ldiff_r) * 61'(LN2_Q28);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= magp[60:8];
      mneg_r <= lneg_r;
    end
  end

  // numerator ln(F/K) + V/2 as sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_w;
      if (!mneg_r) begin
        nmag_r <= 60'(vh_dl[29]) + 60'(mag_r);
        nneg_r <= 1'b0;
      end else if (59'(mag_r) > vh_dl[29]) begin
        nmag_r <= 60'(mag_r) - 60'(vh_dl[29]);
        nneg_r <= 1'b1;
      end else begin
        nmag_r <= 60'(vh_dl[29]) - 60'(mag_r);
        nneg_r <= 1'b0;
      end
    end
  end

  bsd_div u_div (
    .clk(clk), .en(en), .num(nmag_r), .den(s_r),
    .quo(quo), .ovf(ovf), .den_out(sd)
  );

  // sign, d2, clamping and degenerate override
  logic [33:0]        q34;
  logic signed [35:0] d1, d2;
  logic [31:0]        d1c, d2c;
  logic               sat;
  logic [31:0]        o1, o2;
  status_t            ost;

  always_comb begin
    q34 = ovf ? 34'h2_0000_0000 : {1'b0, quo};
    d1  = nneg_dl[33] ? -$signed({2'b0, q34}) : $signed({2'b0, q34});
    d2  = d1 - $signed({6'b0, sd});
    sat = 1'b0;
    if (d1 > 36'sh0_7FFF_FFFF) begin
      d1c = 32'h7FFF_FFFF; sat = 1'b1;
    end else if (d1 < -36'sh0_8000_0000) begin
      d1c = 32'h8000_0000; sat = 1'b1;
    end else d1c = d1[31:0];
    if (d2 > 36'sh0_7FFF_FFFF) begin
      d2c = 32'h7FFF_FFFF; sat = 1'b1;
    end else if (d2 < -36'sh0_8000_0000) begin
      d2c = 32'h8000_0000; sat = 1'b1;
    end else d2c = d2[31:0];
    case (spec_dl[DEPTH-1])
      SP_INVALID: begin o1 = '0; o2 = '0; ost = ST_INVALID; end
      SP_PINF: begin o1 = 32'h7FFF_FFFF; o2 = 32'h7FFF_FFFF; ost = ST_PINF; end
      SP_MINF: begin o1 = 32'h8000_0000; o2 = 32'h8000_0000; ost = ST_MINF; end
      SP_ZERO: begin o1 = '0; o2 = '0; ost = ST_FINITE; end
      default: begin o1 = d1c; o2 = d2c; ost = sat ? ST_SAT : ST_FINITE; end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld_r[DEPTH-1]) out_data_r <= {5'b0, ost, o2, o1};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
`default_nettype none

module tb import bsd_pkg::*; ();

  localparam int LATENCY = 68;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 2000;
  localparam logic [63:0] LN2_FIX = 64'h0B17217F;

  typedef struct packed {
    logic [23:0] mat;
    logic [17:0] vol;
    logic [31:0] strike;
    logic [31:0] fwd;
  } option_t;

  typedef struct packed {
    logic [31:0] d_one;
    logic [31:0] d_two;
    status_t     status;
  } dval_t;

  // directed row: expected result given only where known outright
  typedef struct {
    option_t opt;
    bit      known;
    dval_t   res;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  dval_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  black_scholes_d1_d2_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // log2 as exponent and 28 fraction bits
  function automatic logic [63:0] log2_fix(logic [31:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int e;
    frac = 0;
    e = 31;
    while (e > 0 && !x[e]) e--;
    m = (64'(x) << (31 - e)) & 64'hFFFF_FFFF;
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 28) + frac;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clamp_q824(logic signed [63:0] v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic dval_t compute_d1_d2(option_t o);
    dval_t r;
    logic [63:0] lf, lk, mag, v, s, q;
    logic signed [63:0] n, d1, d2;
    bit neg;
    bit sat;
    sat = 1'b0;
    if (o.fwd == 0 && o.strike == 0) return '{32'd0, 32'd0, ST_INVALID};
    if (o.strike == 0) return '{32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_PINF};
    if (o.fwd == 0) return '{32'h8000_0000, 32'h8000_0000, ST_MINF};
    if (o.vol == 0 || o.mat == 0) begin
      if (o.fwd > o.strike) return '{32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_PINF};
      if (o.fwd == o.strike) return '{32'd0, 32'd0, ST_FINITE};
      return '{32'h8000_0000, 32'h8000_0000, ST_MINF};
    end
    lf = log2_fix(o.fwd);
    lk = log2_fix(o.strike);
    neg = lf < lk;
    mag = neg ? lk - lf : lf - lk;
    mag = (mag * LN2_FIX) >> 8;
    v = 64'(o.vol) * 64'(o.vol) * 64'(o.mat);
    s = int_sqrt(v);
    n = (neg ? -$signed(mag) : $signed(mag)) + $signed(v >> 1);
    if (n < 0) begin
      q = 64'(-n) / s;
      d1 = -$signed(q);
    end else begin
      q = 64'(n) / s;
      d1 = $signed(q);
    end
    d2 = d1 - $signed(s);
    d1 = clamp_q824(d1, sat);
    d2 = clamp_q824(d2, sat);
    r.d_one = d1[31:0];
    r.d_two = d2[31:0];
    r.status = sat ? ST_SAT : ST_FINITE;
    return r;
  endfunction

  function automatic option_t random_option();
    option_t o;
    o.fwd = $urandom();
    o.strike = $urandom();
    o.vol = 18'($urandom());
    o.mat = 24'($urandom());
    // some zero fields or equal prices, some prices near each other and moderate vol/mat to stay finite
    case ($urandom_range(9))
      0: o.fwd = 0;
      1: o.strike = 0;
      2: o.vol = 0;
      3: o.mat = 0;
      4, 5, 6: begin
        o.strike = o.fwd + $urandom_range(32'h20000) - 32'h10000;
        o.vol = 18'($urandom_range(18'h3_FFFF, 18'h800));
        o.mat = 24'($urandom_range(24'h10_0000, 24'h1000));
      end
      7: o.strike = o.fwd;
      default: ;
    endcase
    return o;
  endfunction

  // drive one item, with random idle bursts ahead of it
  task automatic send_option(option_t o);
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, o};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // receiver stall pattern
  initial begin
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_tdata);
        errors++;
      end else begin
        dval_t e;
        dval_t a;
        e = expected_q.pop_front();
        a = {out_tdata[31:0], out_tdata[63:32], status_t'(out_tdata[66:64])};
        if (a.d_one !== e.d_one) begin
          $display("%0t: d_one expected %h actual %h", $time, e.d_one, a.d_one);
          errors++;
        end
        if (a.d_two !== e.d_two) begin
          $display("%0t: d_two expected %h actual %h", $time, e.d_two, a.d_two);
          errors++;
        end
        if (a.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n && expected_q.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    vector_t vectors[$];
    option_t o;
    dval_t exp_res;
    vectors = '{
      '{'{24'h01_0000, 18'h0_4000, 32'd0, 32'd0}, 1,
        '{32'd0, 32'd0, ST_INVALID}},
      '{'{24'hFF_FFFF, 18'h3_FFFF, 32'd0, 32'hFFFF_FFFF}, 1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_PINF}},
      '{'{24'hFF_FFFF, 18'h3_FFFF, 32'hFFFF_FFFF, 32'd0}, 1,
        '{32'h8000_0000, 32'h8000_0000, ST_MINF}},
      '{'{24'h01_0000, 18'd0, 32'h1_0000, 32'h2_0000}, 1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_PINF}},
      '{'{24'd0, 18'h1_0000, 32'h1_0000, 32'h1_0000}, 1,
        '{32'd0, 32'd0, ST_FINITE}},
      '{'{24'd0, 18'd0, 32'h2_0000, 32'h1_0000}, 1,
        '{32'h8000_0000, 32'h8000_0000, ST_MINF}},
      '{'{24'h01_0000, 18'h0_4000, 32'h1_0000, 32'h1_0000}, 0, '{0, 0, ST_FINITE}},
      '{'{24'h01_0000, 18'h0_3333, 32'h0_F000, 32'h1_0000}, 0, '{0, 0, ST_FINITE}},
      '{'{24'hFF_FFFF, 18'h3_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, '{0, 0, ST_FINITE}},
      '{'{24'd1, 18'd1, 32'd1, 32'hFFFF_FFFF}, 0, '{0, 0, ST_FINITE}},
      '{'{24'd1, 18'd1, 32'hFFFF_FFFF, 32'd1}, 0, '{0, 0, ST_FINITE}},
      '{'{24'hFF_FFFF, 18'h3_FFFF, 32'd1, 32'hFFFF_FFFF}, 0, '{0, 0, ST_FINITE}},
      '{'{24'hFF_FFFF, 18'h3_FFFF, 32'hFFFF_FFFF, 32'd1}, 0, '{0, 0, ST_FINITE}},
      '{'{24'h00_0001, 18'h3_FFFF, 32'h1_0000, 32'h1_0000}, 0, '{0, 0, ST_FINITE}},
      '{'{24'hAA_AAAA, 18'h2_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, 0, '{0, 0, ST_FINITE}},
      '{'{24'h55_5555, 18'h1_5555, 32'h5555_5555, 32'hAAAA_AAAA}, 0, '{0, 0, ST_FINITE}}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (vectors[i]) begin
      exp_res = vectors[i].known ? vectors[i].res : compute_d1_d2(vectors[i].opt);
      expected_q.push_back(exp_res);
      send_option(vectors[i].opt);
    end

    // random items, the tail without idling
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) quiet = 1'b1;
      o = random_option();
      expected_q.push_back(compute_d1_d2(o));
      send_option(o);
    end
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
